[src/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg: shared constants and types of the shock filter pass
// Pixel and counter widths, line store geometry, register indexes and
// reset values, and the result kinds of one input pixel.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int PIX_W      = 16;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 16;
	localparam int WID_W      = 7;
	localparam int STR_W      = 16;
	localparam int DATA_W     = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int MAX_WIDTH   = 64;
	localparam int LINE_ROWS   = 3;
	localparam int BANK_W      = 2;
	localparam int ADDR_W      = BANK_W + COL_W;
	localparam int STORE_DEPTH = LINE_ROWS * MAX_WIDTH;

	localparam logic [WID_W-1:0] MIN_WIDTH_V  = WID_W'(2);
	localparam logic [WID_W-1:0] MAX_WIDTH_V  = WID_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] MIN_HEIGHT_V = ROW_W'(2);
	localparam logic [STR_W-1:0] ONE_Q15      = STR_W'(32768);
	localparam int               HALF_Q15     = 16384;
	localparam int               FRAC_BITS    = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH     = CFG_IDX_W'(2);

	localparam logic [WID_W-1:0] RST_IMAGE_WIDTH  = WID_W'(64);
	localparam logic [ROW_W-1:0] RST_IMAGE_HEIGHT = ROW_W'(64);
	localparam logic [STR_W-1:0] RST_STRENGTH     = STR_W'(16384);

	localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(LINE_ROWS - 1);

	// result kinds, one bit each in a pending mask
	localparam int KIND_N    = 3;
	localparam int KIND_UP   = 0;
	localparam int KIND_PREV = 1;
	localparam int KIND_END  = 2;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [KIND_N-1:0] kind_mask_t;

endpackage

[src/shock_filter_pass.sv]
// ----------------------------------------------------------------------------
// shock_filter_pass: one shock filter pass over a raster pixel stream
// Line store in one synchronous memory, 4-neighbour cross with mirrored
// borders, min/max shock by Laplacian sign and a Q1.15 blend with the
// original pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: pixel_in with in_valid; in_stall holds the transfer.
//   Output channel: pixel_out, out_column, out_row, frame_done with out_valid;
//   out_stall from the receiver holds the output register, and the block keeps
//   taking pixels until its three stages fill up.
//   Results trail the input by one row: pixel (r-1,c) comes out on input (r,c).
//   On the last row each pixel past the first column gives two results and the
//   final one three; frame_done marks the very last one.
//   Throughput while out_stall does not hold the output: one pixel per cycle,
//   except on the last row, where stage 1 hands one result per cycle to the
//   blend stage and takes the next pixel as it hands on the last result of
//   the current one. Each result is registered in stage 1, then stage 2,
//   then the output register.
//   The line store has one write and two read ports; every read hits a row
//   other than the one being written, so no forwarding is required.
//   Reset clears counters, pipeline valids and registers to their defaults;
//   the line store is not cleared, and the first frame fills it before use.
//   Registers are written through cfg_write, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module shock_filter_pass
	import sfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     pixel_out,
	output logic [COL_W-1:0]     out_column,
	output logic [ROW_W-1:0]     out_row,
	output logic                 frame_done
);

	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [STR_W-1:0] strength_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [BANK_W-1:0] bank_q;
	pix_t              x1_q;
	pix_t              x2_q;
	pix_t              cur0_q;
	pix_t              h1_q;
	pix_t              h2_q;

	pix_t store_mem [0:STORE_DEPTH-1];

	logic             v_s1;
	kind_mask_t       pend_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	pix_t             pix_s1;
	pix_t             x1_s1;
	pix_t             x2_s1;
	pix_t             p0_s1;
	logic             re_s1;
	logic             cgw_s1;
	logic             r1_s1;
	pix_t             rda_s1;
	pix_t             rdb_s1;

	logic             v_s2;
	pix_t             sh_s2;
	pix_t             ctr_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;
	logic             done_s2;

	logic             v_s3;
	pix_t             pix_s3;
	logic [COL_W-1:0] col_s3;
	logic [ROW_W-1:0] row_s3;
	logic             done_s3;

	// ---- input side
	logic [WID_W-1:0]  w_eff;
	logic [ROW_W-1:0]  h_eff;
	logic              row_end0;
	logic              cgw0;
	logic              last0;
	logic              r_ge1;
	kind_mask_t        pend0;
	logic [BANK_W-1:0] bank_m1;
	logic [BANK_W-1:0] bank_m2;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rda_addr;
	logic [ADDR_W-1:0] rdb_addr;
	logic              acc;

	always_comb begin
		if (width_q < MIN_WIDTH_V) begin
			w_eff = MIN_WIDTH_V;
		end else if (width_q > MAX_WIDTH_V) begin
			w_eff = MAX_WIDTH_V;
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < MIN_HEIGHT_V) ? MIN_HEIGHT_V : height_q;
	end

	assign row_end0 = ({1'b0, col_q} + WID_W'(1)) >= w_eff;
	assign cgw0     = {1'b0, col_q} >= w_eff;
	assign last0    = ({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
	assign r_ge1    = row_q != '0;

	always_comb begin
		pend0            = '0;
		pend0[KIND_UP]   = r_ge1;
		pend0[KIND_PREV] = last0 && r_ge1 && (col_q != '0);
		pend0[KIND_END]  = last0 && r_ge1 && row_end0;
	end

	assign bank_m1  = (bank_q == '0) ? LAST_BANK : bank_q - BANK_W'(1);
	assign bank_m2  = (bank_q == LAST_BANK) ? '0 : bank_q + BANK_W'(1);
	assign wr_addr  = {bank_q, col_q};
	assign rda_addr = {bank_m1, col_q + COL_W'(1)};
	assign rdb_addr = {bank_m2, col_q};

	// ---- stage 1 control
	kind_mask_t low_bit;
	kind_mask_t pend_rest;
	logic       s2_free;
	logic       emit;
	logic       done_now;
	logic       s1_free;
	logic       out_load;

	assign low_bit   = pend_s1 & (~pend_s1 + kind_mask_t'(1));
	assign pend_rest = pend_s1 & ~low_bit;
	assign out_load  = v_s2 && (!v_s3 || !out_stall);
	assign s2_free   = !v_s2 || out_load;
	assign emit      = v_s1 && (pend_s1 != '0) && s2_free;
	assign done_now  = v_s1 && ((pend_s1 == '0) || (s2_free && (pend_rest == '0)));
	assign s1_free   = !v_s1 || done_now;
	assign acc       = in_valid && s1_free;
	assign in_stall  = !s1_free;

	// ---- stage 1 datapath
	pix_t             u_c;
	pix_t             u_l;
	pix_t             u_r;
	pix_t             ctr;
	pix_t             nl;
	pix_t             nr;
	pix_t             nu;
	pix_t             nd;
	logic [COL_W-1:0] col_r;
	logic [ROW_W-1:0] row_r;
	logic             done_r;
	logic [PIX_W+1:0] nsum;
	logic [PIX_W+1:0] c4;
	pix_t             mn;
	pix_t             mx;
	pix_t             sh;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a > b) ? a : b;
	endfunction

	assign u_c = (col_s1 == '0) ? p0_s1 : h1_q;
	assign u_l = (col_s1 == '0) ? rda_s1 : h2_q;
	assign u_r = re_s1 ? h2_q : rda_s1;

	always_comb begin
		ctr    = u_c;
		nl     = u_l;
		nr     = u_r;
		nd     = pix_s1;
		nu     = r1_s1 ? pix_s1 : rdb_s1;
		row_r  = row_s1 - ROW_W'(1);
		col_r  = col_s1;
		done_r = 1'b0;
		if (!low_bit[KIND_UP]) begin
			if (low_bit[KIND_PREV]) begin
				ctr   = x1_s1;
				nl    = (col_s1 == COL_W'(1)) ? pix_s1 : x2_s1;
				nr    = cgw_s1 ? x2_s1 : pix_s1;
				nu    = h2_q;
				nd    = h2_q;
				row_r = row_s1;
				col_r = col_s1 - COL_W'(1);
			end else begin
				ctr    = pix_s1;
				nl     = x1_s1;
				nr     = x1_s1;
				nu     = u_c;
				nd     = u_c;
				row_r  = row_s1;
				done_r = 1'b1;
			end
		end
	end

	assign nsum = {2'b00, nl} + {2'b00, nr} + {2'b00, nu} + {2'b00, nd};
	assign c4   = {ctr, 2'b00};
	assign mn   = min2(min2(min2(nl, nr), min2(nu, nd)), ctr);
	assign mx   = max2(max2(max2(nl, nr), max2(nu, nd)), ctr);
	assign sh   = (nsum > c4) ? mn : ((nsum < c4) ? mx : ctr);

	// ---- blend
	logic [STR_W-1:0]   s_eff;
	logic signed [16:0] s_ext;
	logic signed [16:0] diff;
	logic signed [33:0] prod;
	logic signed [33:0] rnd;
	logic signed [33:0] blend;

	assign s_eff = (strength_q > ONE_Q15) ? ONE_Q15 : strength_q;
	assign s_ext = signed'({1'b0, s_eff});
	assign diff  = signed'({1'b0, sh_s2}) - signed'({1'b0, ctr_s2});
	assign prod  = s_ext * diff;
	assign rnd   = (prod + 34'sd16384) >>> FRAC_BITS;
	assign blend = signed'({18'b0, ctr_s2}) + rnd;

	// ---- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_IMAGE_WIDTH;
			height_q   <= RST_IMAGE_HEIGHT;
			strength_q <= RST_STRENGTH;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q    <= cfg_data[WID_W-1:0];
				CFG_IMAGE_HEIGHT: height_q   <= cfg_data[ROW_W-1:0];
				CFG_STRENGTH:     strength_q <= cfg_data[STR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- line store
	always_ff @(posedge clk) begin
		if (acc) begin
			store_mem[wr_addr] <= pixel_in;
			rda_s1             <= store_mem[rda_addr];
			rdb_s1             <= store_mem[rdb_addr];
		end
	end

	// ---- counters and row history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= '0;
		end else if (acc) begin
			if (row_end0) begin
				col_q <= '0;
				if (last0) begin
					row_q  <= '0;
					bank_q <= '0;
				end else begin
					row_q  <= row_q + ROW_W'(1);
					bank_q <= (bank_q == LAST_BANK) ? '0 : bank_q + BANK_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x1_q <= pixel_in;
			x2_q <= x1_q;
			if (col_q == '0) begin
				cur0_q <= pixel_in;
			end
		end
		if (done_now) begin
			h1_q <= rda_s1;
			h2_q <= u_c;
		end
	end

	// ---- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			pend_s1 <= '0;
		end else if (acc) begin
			v_s1    <= 1'b1;
			pend_s1 <= pend0;
		end else if (done_now) begin
			v_s1    <= 1'b0;
			pend_s1 <= '0;
		end else if (emit) begin
			pend_s1 <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1 <= col_q;
			row_s1 <= row_q;
			pix_s1 <= pixel_in;
			x1_s1  <= x1_q;
			x2_s1  <= x2_q;
			p0_s1  <= cur0_q;
			re_s1  <= row_end0;
			cgw_s1 <= cgw0;
			r1_s1  <= row_q == ROW_W'(1);
		end
	end

	// ---- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (emit) begin
			v_s2 <= 1'b1;
		end else if (out_load) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sh_s2   <= sh;
			ctr_s2  <= ctr;
			col_s2  <= col_r;
			row_s2  <= row_r;
			done_s2 <= done_r;
		end
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (out_load) begin
			v_s3 <= 1'b1;
		end else if (!out_stall) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_s3  <= blend[PIX_W-1:0];
			col_s3  <= col_s2;
			row_s3  <= row_s2;
			done_s3 <= done_s2;
		end
	end

	assign out_valid  = v_s3;
	assign pixel_out  = pix_s3;
	assign out_column = col_s3;
	assign out_row    = row_s3;
	assign frame_done = done_s3;

`ifndef SYNTHESIS
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> (pend_s1 == '0))
		else $error("pending results without an item in stage 1");

	a_bank_range: assert property (@(posedge clk) disable iff (!arst_n)
		bank_q != 2'd3)
		else $error("line store bank out of range");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last0 && row_end0) |=> (col_q == '0 && row_q == '0 && bank_q == '0))
		else $error("counters did not wrap at frame end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (!v_s1 || pend_s1 == '0 || ($countones(pend_s1) == 1 && emit)))
		else $error("transfer accepted while stage 1 still owes results");
`endif

endmodule

[tb/tb_shock_filter_pass.sv]
// ----------------------------------------------------------------------------
// tb_shock_filter_pass: self-checking bench for the shock filter pass
// Streams whole frames of grey pixels through the block under several frame
// sizes, strengths and idle mixes. An in-bench line store predicts every
// filtered pixel with its row, column and frame end flag. Each result is
// compared in order against the prediction.
// ----------------------------------------------------------------------------
module tb_shock_filter_pass;
	import sfp_pkg::*;

	localparam int RANDOM_ITEMS   = 145;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		pix_t             value;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             last;
	} filtered_t;

	typedef enum int unsigned {PIX_NOISE, PIX_EXTREME, PIX_RIPPLE, PIX_SPIKE} pix_style_t;

	class shock_pass_predictor;
		pix_t              lines[LINE_ROWS][MAX_WIDTH];
		int unsigned       col_pos;
		int unsigned       row_pos;
		logic [WID_W-1:0]  width_reg;
		logic [ROW_W-1:0]  height_reg;
		logic [STR_W-1:0]  strength_reg;
		filtered_t         awaited[$];
		int unsigned       faults;
		int unsigned       checked;

		function new();
			col_pos      = 0;
			row_pos      = 0;
			width_reg    = RST_IMAGE_WIDTH;
			height_reg   = RST_IMAGE_HEIGHT;
			strength_reg = RST_STRENGTH;
			faults       = 0;
			checked      = 0;
		endfunction

		function int unsigned span();
			int unsigned v;
			v = width_reg;
			if (v < 2)
				return 2;
			if (v > MAX_WIDTH)
				return MAX_WIDTH;
			return v;
		endfunction

		function int unsigned depth_rows();
			return (height_reg < MIN_HEIGHT_V) ? 2 : height_reg;
		endfunction

		function int unsigned frame_pixels();
			return span() * depth_rows();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
			case (idx)
				CFG_IMAGE_WIDTH:  width_reg    = v[WID_W-1:0];
				CFG_IMAGE_HEIGHT: height_reg   = v[ROW_W-1:0];
				CFG_STRENGTH:     strength_reg = v[STR_W-1:0];
				default: ;
			endcase
		endfunction

		function void shock_blend(int unsigned r, int unsigned c, int unsigned up,
				int unsigned dn, int unsigned w, logic last);
			int unsigned       lc, rc, sum, s;
			pix_t              centre, shocked;
			pix_t              nb[4];
			longint unsigned   acc;
			filtered_t         f;
			lc = (c == 0) ? 1 : c - 1;
			rc = (c + 1 >= w) ? c - 1 : c + 1;
			centre = lines[r % LINE_ROWS][c];
			nb[0] = lines[r % LINE_ROWS][rc];
			nb[1] = lines[r % LINE_ROWS][lc];
			nb[2] = lines[dn % LINE_ROWS][c];
			nb[3] = lines[up % LINE_ROWS][c];
			sum = 0;
			foreach (nb[k])
				sum += nb[k];
			shocked = centre;
			if (sum > 4 * int'(centre)) begin
				foreach (nb[k])
					if (nb[k] < shocked)
						shocked = nb[k];
			end else if (sum < 4 * int'(centre)) begin
				foreach (nb[k])
					if (nb[k] > shocked)
						shocked = nb[k];
			end
			s = (strength_reg > ONE_Q15) ? ONE_Q15 : strength_reg;
			acc = 64'(s) * 64'(shocked) + 64'(int'(ONE_Q15) - s) * 64'(centre) + 64'(HALF_Q15);
			f.value  = pix_t'(acc >> FRAC_BITS);
			f.column = c[COL_W-1:0];
			f.row    = r[ROW_W-1:0];
			f.last   = last;
			awaited.push_back(f);
		endfunction

		function void absorb_pixel(pix_t p);
			int unsigned w, h, r, c;
			logic        row_end, last_row;
			w = span();
			h = depth_rows();
			r = row_pos;
			c = col_pos;
			lines[r % LINE_ROWS][c] = p;
			row_end  = (c + 1 >= w);
			last_row = (r + 1 >= h);
			if (r >= 1)
				shock_blend(r - 1, c, (r == 1) ? r : r - 2, r, w, 1'b0);
			if (last_row && r >= 1) begin
				if (c >= 1)
					shock_blend(r, c - 1, r - 1, r - 1, w, 1'b0);
				if (row_end)
					shock_blend(r, c, r - 1, r - 1, w, 1'b1);
			end
			if (row_end) begin
				col_pos = 0;
				row_pos = last_row ? 0 : ((r + 1) & 32'hFFFF);
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void match_filtered(pix_t v, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
				logic done);
			filtered_t e;
			if (awaited.size() == 0) begin
				$error("unexpected filtered pixel at row %0d column %0d", row, col);
				faults++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (v !== e.value) begin
				$error("pixel_out: expected %0d, got %0d", e.value, v);
				faults++;
			end
			if (col !== e.column) begin
				$error("out_column: expected %0d, got %0d", e.column, col);
				faults++;
			end
			if (row !== e.row) begin
				$error("out_row: expected %0d, got %0d", e.row, row);
				faults++;
			end
			if (done !== e.last) begin
				$error("frame_done: expected %0d, got %0d", e.last, done);
				faults++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel_in;
	logic                 out_valid;
	logic                 out_stall;
	logic [PIX_W-1:0]     pixel_out;
	logic [COL_W-1:0]     out_column;
	logic [ROW_W-1:0]     out_row;
	logic                 frame_done;

	shock_pass_predictor pred;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned hold_off_cycles;
	int unsigned pixels_sent;
	int unsigned random_items;
	int unsigned frames;
	int unsigned quiet;
	int unsigned idle_send[4]  = '{0, 87, 0, 23};
	int unsigned idle_stall[4] = '{0, 0, 87, 23};

	shock_filter_pass uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.out_column (out_column),
		.out_row    (out_row),
		.frame_done (frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_stall = 1'b0;
		hold_off_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				hold_off_cycles--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			pred.absorb_pixel(pixel_in);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			pred.match_filtered(pixel_out, out_column, out_row, frame_done);
	end

	initial begin
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic set_idling(int unsigned phase);
		send_idle_pct = idle_send[phase % 4];
		stall_pct     = idle_stall[phase % 4];
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		pred.set_register(idx, v);
	endtask

	task automatic program_regs(logic [DATA_W-1:0] w, logic [DATA_W-1:0] h,
			logic [DATA_W-1:0] s);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_STRENGTH, s);
		cfg_write <= 1'b0;
	endtask

	task automatic send_pixel(pix_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
	endtask

	// drop valid, wait out every pending result, then let the pipe settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pred.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic pix_t pick_pixel(pix_style_t style, pix_t base);
		case (style)
			PIX_NOISE: return pix_t'($urandom);
			PIX_EXTREME: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return pix_t'(16'h8000);
					default: return pix_t'(16'h7FFF);
				endcase
			end
			PIX_RIPPLE: return base + pix_t'($urandom_range(2));
			default: return ($urandom_range(9) == 0) ? pix_t'($urandom) : base;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_strength();
		case ($urandom_range(5))
			0: return '0;
			1: return DATA_W'(ONE_Q15);
			2: return DATA_W'($urandom_range(65535, 32769));
			default: return DATA_W'($urandom_range(32767));
		endcase
	endfunction

	task automatic random_frame(pix_style_t style, int pause_at);
		int   n;
		pix_t base;
		n = pred.frame_pixels();
		base = pix_t'($urandom_range(65000));
		for (int k = 0; k < n; k++) begin
			if (k == pause_at)
				quiesce();
			send_pixel(pick_pixel(style, base));
			random_items++;
		end
		quiesce();
	endtask

	initial begin
		pix_t frame_a[4] = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
		pix_t frame_b[9] = '{16'd0, 16'd500, 16'd65535, 16'd3000, 16'd1000, 16'd3000,
			16'd3500, 16'd3000, 16'd3000};
		pix_t frame_c[8] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd7, 16'd7,
			16'd7, 16'd7};
		pix_t frame_c_tail[2] = '{16'd7, 16'hFF00};

		pred = new();
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = CFG_IMAGE_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pixel_in    = '0;
		pixels_sent = 0;
		random_items = 0;
		frames      = 0;
		set_idling(0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// smallest frame, width and height below range, strength above one
		program_regs(16'h0001, 16'h0001, 16'hFFFF);
		set_idling(frames++);
		foreach (frame_a[i])
			send_pixel(frame_a[i]);
		quiesce();

		// 3x3 frame with min and max shocks that move the pixel
		program_regs(16'd3, 16'd3, DATA_W'(ONE_Q15));
		set_idling(frames++);
		foreach (frame_b[i])
			send_pixel(frame_b[i]);
		quiesce();

		// tall frame cut short by lowering the height mid-frame, flat rows
		program_regs(16'hFF80, 16'hFFFF, 16'h0000);
		set_idling(frames++);
		foreach (frame_c[i])
			send_pixel(frame_c[i]);
		quiesce();
		write_reg(CFG_IMAGE_HEIGHT, 16'h0000);
		cfg_write <= 1'b0;
		foreach (frame_c_tail[i])
			send_pixel(frame_c_tail[i]);
		quiesce();

		// widest frame: hold the output long enough to back up the input
		program_regs(16'hFFC1, 16'd2, pick_strength());
		set_idling(frames++);
		hold_off_cycles = LONG_HOLD;
		random_frame(PIX_NOISE, 96);

		while (random_items < RANDOM_ITEMS) begin
			program_regs(DATA_W'($urandom_range(9)), DATA_W'($urandom_range(6)),
				pick_strength());
			set_idling(frames++);
			random_frame(pix_style_t'($urandom_range(3)), -1);
		end

		$display("Streamed %0d pixels in %0d frames, %0d filtered pixels checked",
			pixels_sent, frames, pred.checked);
		$display("Widths 2 to 64, clamped sizes, strengths 0 to saturated, four idle mixes");
		if (pred.faults == 0 && pred.awaited.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
